// ===== sv/ps2h_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2h_pkg
// Shared widths, codes and word types for the PS/2 host line controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2h_pkg;

	// Register widths
	localparam int DELAY_WIDTH   = 16;
	localparam int TIMEOUT_WIDTH = 24;
	localparam int CNT_WIDTH     = (DELAY_WIDTH > TIMEOUT_WIDTH) ? DELAY_WIDTH : TIMEOUT_WIDTH;
	localparam int CFG_IDX_WIDTH = 3;
	// config write data spans the widest register
	localparam int CFG_DATA_WIDTH = CNT_WIDTH;

	// Register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_INHIBIT = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_REQUEST = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START   = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT = 3'd4;

	// Reset values
	localparam logic [DELAY_WIDTH-1:0]   INHIBIT_RST = DELAY_WIDTH'(300);
	localparam logic [DELAY_WIDTH-1:0]   REQUEST_RST = DELAY_WIDTH'(10);
	localparam logic [DELAY_WIDTH-1:0]   RELEASE_RST = DELAY_WIDTH'(50);
	localparam logic [DELAY_WIDTH-1:0]   START_RST   = DELAY_WIDTH'(5);
	localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RST = '0;

	// Command codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SEND = 2'd1;
	localparam logic [1:0] OP_RECV = 2'd2;

	// Stream widths
	localparam int IN_DATA_WIDTH  = 16;
	localparam int IN_USER_WIDTH  = 2;
	localparam int RES_WIDTH      = 14;
	localparam int OUT_DATA_WIDTH = 16;

	typedef struct packed {
		logic [DELAY_WIDTH-1:0]   inhibit_ticks;
		logic [DELAY_WIDTH-1:0]   request_ticks;
		logic [DELAY_WIDTH-1:0]   release_ticks;
		logic [DELAY_WIDTH-1:0]   start_ticks;
		logic [TIMEOUT_WIDTH-1:0] timeout_ticks;
	} cfg_t;

	// Result word, MSB first; clk_pull_low lands in bit 0
	typedef struct packed {
		logic       busy_res;
		logic       tx_timeout;
		logic       tx_done;
		logic       rx_done;
		logic [7:0] rx_byte;
		logic       data_pull_low;
		logic       clk_pull_low;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/ps2h_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ps2h_cfg_regs
// Timing registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2h_cfg_regs (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [ps2h_pkg::CFG_IDX_WIDTH-1:0]  cfg_addr,
	input  wire [ps2h_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
	output ps2h_pkg::cfg_t                     cfg
);

	ps2h_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inhibit_ticks <= ps2h_pkg::INHIBIT_RST;
			cfg_q.request_ticks <= ps2h_pkg::REQUEST_RST;
			cfg_q.release_ticks <= ps2h_pkg::RELEASE_RST;
			cfg_q.start_ticks   <= ps2h_pkg::START_RST;
			cfg_q.timeout_ticks <= ps2h_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				ps2h_pkg::REG_INHIBIT: begin
					cfg_q.inhibit_ticks <= cfg_wdata[ps2h_pkg::DELAY_WIDTH-1:0];
				end
				ps2h_pkg::REG_REQUEST: begin
					cfg_q.request_ticks <= cfg_wdata[ps2h_pkg::DELAY_WIDTH-1:0];
				end
				ps2h_pkg::REG_RELEASE: begin
					cfg_q.release_ticks <= cfg_wdata[ps2h_pkg::DELAY_WIDTH-1:0];
				end
				ps2h_pkg::REG_START: begin
					cfg_q.start_ticks <= cfg_wdata[ps2h_pkg::DELAY_WIDTH-1:0];
				end
				ps2h_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_ticks <= cfg_wdata[ps2h_pkg::TIMEOUT_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/ps2h_core.sv =====
// ----------------------------------------------------------------------------
// ps2h_core
// Line sequencer: one tick per word, next state and result computed in one
// pass, result held in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2h_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ps2h_pkg::cfg_t       cfg,
	input  wire                  in_valid,
	input  wire [1:0]            op,
	input  wire [7:0]            tx_byte,
	input  wire                  clk_level,
	input  wire                  data_level,
	output logic                 take,
	output logic                 out_valid,
	input  wire                  out_ready,
	output ps2h_pkg::res_t       res
);

	localparam int CW = ps2h_pkg::CNT_WIDTH;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_S_REL,
		PH_S_INH,
		PH_S_REQ,
		PH_S_WSTART,
		PH_S_BHIGH,
		PH_S_BLOW,
		PH_S_ACKDLY,
		PH_S_ACKLOW,
		PH_S_EITHER,
		PH_R_DLY,
		PH_R_SLOW,
		PH_R_SDLY,
		PH_R_SHIGH,
		PH_R_BLOW,
		PH_R_BHIGH
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   wait_q, wait_d, cnt_inc;
	logic [7:0]      sr_q, sr_d;
	logic [3:0]      idx_q, idx_d;
	logic            par_q, par_d;
	logic [7:0]      rx_hold_q, rx_hold_d;
	logic            hold_low_q, hold_low_d;
	logic            out_valid_q;
	ps2h_pkg::res_t  res_q, res_d;

	logic [ps2h_pkg::DELAY_WIDTH-1:0] dly_n;
	logic            dly_hit, to_hit, wait_cond;
	logic            rx_done, tx_done, tx_to, cp, dp;

	assign take = in_valid && (!out_valid_q || out_ready);

	// Saturating tick counter and the two limit compares
	assign cnt_inc = (wait_q == {CW{1'b1}}) ? wait_q : wait_q + 1'b1;
	assign dly_hit = (dly_n == '0) || (cnt_inc >= CW'(dly_n));
	assign to_hit  = (cfg.timeout_ticks != '0) && (cnt_inc >= CW'(cfg.timeout_ticks));

	// Fixed delay length for the current phase
	always_comb begin
		case (phase_q)
			PH_S_REL, PH_S_INH:    dly_n = cfg.inhibit_ticks;
			PH_S_REQ:              dly_n = cfg.request_ticks;
			PH_S_ACKDLY, PH_R_DLY: dly_n = cfg.release_ticks;
			PH_R_SDLY:             dly_n = cfg.start_ticks;
			default:               dly_n = cfg.inhibit_ticks;
		endcase
	end

	// Condition for the bounded send waits
	always_comb begin
		case (phase_q)
			PH_S_BHIGH:  wait_cond = clk_level;
			PH_S_EITHER: wait_cond = clk_level || data_level;
			default:     wait_cond = !clk_level;
		endcase
	end

	// Next state for one tick
	always_comb begin
		phase_d    = phase_q;
		wait_d     = wait_q;
		sr_d       = sr_q;
		idx_d      = idx_q;
		par_d      = par_q;
		rx_hold_d  = rx_hold_q;
		hold_low_d = hold_low_q;
		rx_done    = 1'b0;
		tx_done    = 1'b0;
		tx_to      = 1'b0;
		if (phase_q == PH_IDLE && (op == ps2h_pkg::OP_SEND || op == ps2h_pkg::OP_RECV)) begin
			wait_d     = '0;
			idx_d      = '0;
			par_d      = 1'b1;
			hold_low_d = 1'b0;
			sr_d       = (op == ps2h_pkg::OP_SEND) ? tx_byte : 8'h00;
			phase_d    = (op == ps2h_pkg::OP_SEND) ? PH_S_REL : PH_R_DLY;
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				// fixed delays
				PH_S_REL, PH_S_INH, PH_S_REQ, PH_S_ACKDLY, PH_R_DLY, PH_R_SDLY: begin
					if (dly_hit) begin
						wait_d = '0;
						case (phase_q)
							PH_S_REL:    phase_d = PH_S_INH;
							PH_S_INH:    phase_d = PH_S_REQ;
							PH_S_REQ:    phase_d = PH_S_WSTART;
							PH_S_ACKDLY: phase_d = PH_S_ACKLOW;
							PH_R_DLY:    phase_d = PH_R_SLOW;
							default:     phase_d = PH_R_SHIGH;
						endcase
					end else begin
						wait_d = cnt_inc;
					end
				end
				// bounded send waits
				PH_S_WSTART, PH_S_BHIGH, PH_S_BLOW, PH_S_ACKLOW, PH_S_EITHER: begin
					if (wait_cond) begin
						wait_d = '0;
						case (phase_q)
							PH_S_WSTART: phase_d = PH_S_BHIGH;
							PH_S_BHIGH:  phase_d = PH_S_BLOW;
							PH_S_BLOW: begin
								if (idx_q < 4'd8) begin
									par_d   = par_q ^ sr_q[0];
									sr_d    = {1'b0, sr_q[7:1]};
									idx_d   = idx_q + 1'b1;
									phase_d = PH_S_BHIGH;
								end else begin
									phase_d = PH_S_ACKDLY;
								end
							end
							PH_S_ACKLOW: phase_d = PH_S_EITHER;
							default: begin
								phase_d    = PH_IDLE;
								hold_low_d = 1'b1;
								tx_done    = 1'b1;
							end
						endcase
					end else if (to_hit) begin
						wait_d     = '0;
						phase_d    = PH_IDLE;
						hold_low_d = 1'b1;
						tx_to      = 1'b1;
					end else begin
						wait_d = cnt_inc;
					end
				end
				// receive: unbounded edge waits
				PH_R_SLOW: begin
					if (!clk_level) phase_d = PH_R_SDLY;
				end
				PH_R_SHIGH: begin
					if (clk_level) phase_d = PH_R_BLOW;
				end
				PH_R_BLOW: begin
					if (!clk_level) begin
						if (idx_q < 4'd8) sr_d = {data_level, sr_q[7:1]};
						idx_d   = idx_q + 1'b1;
						phase_d = PH_R_BHIGH;
					end
				end
				PH_R_BHIGH: begin
					if (clk_level) begin
						if (idx_q >= 4'd10) begin
							rx_hold_d  = sr_q;
							rx_done    = 1'b1;
							hold_low_d = 1'b1;
							phase_d    = PH_IDLE;
						end else begin
							phase_d = PH_R_BLOW;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Line drives after this tick
	always_comb begin
		cp = 1'b0;
		dp = 1'b0;
		case (phase_d)
			PH_IDLE:     cp = hold_low_d;
			PH_S_INH:    cp = 1'b1;
			PH_S_REQ: begin
				cp = 1'b1;
				dp = 1'b1;
			end
			PH_S_WSTART: dp = 1'b1;
			PH_S_BHIGH, PH_S_BLOW: begin
				dp = (idx_d < 4'd8) ? ~sr_d[0] : ~par_d;
			end
			default: begin
			end
		endcase
		res_d.clk_pull_low  = cp;
		res_d.data_pull_low = dp;
		res_d.rx_byte       = rx_hold_d;
		res_d.rx_done       = rx_done;
		res_d.tx_done       = tx_done;
		res_d.tx_timeout    = tx_to;
		res_d.busy_res      = (phase_d != PH_IDLE);
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			wait_q      <= '0;
			sr_q        <= '0;
			idx_q       <= '0;
			par_q       <= 1'b1;
			rx_hold_q   <= '0;
			hold_low_q  <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			wait_q      <= wait_d;
			sr_q        <= sr_d;
			idx_q       <= idx_d;
			par_q       <= par_d;
			rx_hold_q   <= rx_hold_d;
			hold_low_q  <= hold_low_d;
			out_valid_q <= 1'b1;
			res_q       <= res_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== sv/ps2_host_line_controller.sv =====
// ----------------------------------------------------------------------------
// ps2_host_line_controller
// PS/2 host: samples line levels one tick per word and drives open-drain
// pull-low controls for the clock and data lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one word per sampling tick carrying the sampled clock and
//   data line levels and a command (tick, send, receive) in s_tuser. A send
//   or receive command taken while idle only starts the sequence; while busy
//   it counts as a plain tick.
//   Output stream: one word per input word with the pull-low controls, the
//   last received byte and one-word done/timeout flags plus busy.
//   Timing registers are written through cfg_we/cfg_addr/cfg_wdata; the user
//   must write them only while idle, as the block does not enforce it.
//   Path: input register, then the sequencer pass into the result register.
//   Throughput: one word per cycle while not stalled, set by the single-pass sequencer update.
//   Reset: sequencer idle, both lines released, timing registers at defaults.
//   Output stall: the result register holds; a new word still enters the
//   input register, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_host_line_controller (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// config write port
	input  wire                                 cfg_we,
	input  wire [ps2h_pkg::CFG_IDX_WIDTH-1:0]   cfg_addr,
	input  wire [ps2h_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	// input stream
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [ps2h_pkg::IN_DATA_WIDTH-1:0]   s_tdata,   // tx_byte[7:0], clk_level, data_level
	input  wire [ps2h_pkg::IN_USER_WIDTH-1:0]   s_tuser,   // op[1:0]
	// output stream
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [ps2h_pkg::OUT_DATA_WIDTH-1:0] m_tdata    // clk_pull_low, data_pull_low,
	                                                       // rx_byte[7:0], rx_done, tx_done,
	                                                       // tx_timeout, busy_res
);

	ps2h_pkg::cfg_t cfg;
	ps2h_pkg::res_t res;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] txb_s1;
	logic       clkl_s1;
	logic       datl_s1;
	logic       take;

	ps2h_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= ps2h_pkg::OP_TICK;
			txb_s1   <= '0;
			clkl_s1  <= 1'b0;
			datl_s1  <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
			op_s1    <= s_tuser[1:0];
			txb_s1   <= s_tdata[7:0];
			clkl_s1  <= s_tdata[8];
			datl_s1  <= s_tdata[9];
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	ps2h_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (valid_s1),
		.op         (op_s1),
		.tx_byte    (txb_s1),
		.clk_level  (clkl_s1),
		.data_level (datl_s1),
		.take       (take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {{(ps2h_pkg::OUT_DATA_WIDTH - ps2h_pkg::RES_WIDTH){1'b0}}, res};

endmodule

`default_nettype wire

// ===== sv/ps2h_checker.sv =====
// ----------------------------------------------------------------------------
// ps2h_checker
// Port-level checks for the PS/2 host line controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2h_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_tvalid,
	input wire                                 s_tready,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [ps2h_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// With the output empty an offered input word is taken
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !m_tvalid |-> s_tready)
		else $error("input word refused with empty output");

	// At most one completion flag per word
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[12:10]))
		else $error("more than one completion flag");

	// A completed command leaves the block idle with the clock held low
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10] || m_tdata[11] || m_tdata[12])
		|-> !m_tdata[13] && m_tdata[0] && !m_tdata[1])
		else $error("completion without idle and clock hold");

	// Idle never pulls data low
	a_idle_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[13] |-> !m_tdata[1])
		else $error("data pulled low while idle");

endmodule

bind ps2_host_line_controller ps2h_checker u_ps2h_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 host line controller. Words carrying the
// sampled line levels and commands are streamed in with random gaps while the
// result stream is stalled at random. Every accepted word runs through a
// line-level model of the host sequencer. Each result word is then compared
// field by field against the model's prediction.
// ----------------------------------------------------------------------------

module tb;
	import ps2h_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;   // unused command, acts as a tick
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [4:0] {
		LN_IDLE, LN_S_REL, LN_S_INH, LN_S_REQ, LN_S_WSTART, LN_S_BHIGH, LN_S_BLOW,
		LN_S_ACKDLY, LN_S_ACKLOW, LN_S_EITHER, LN_R_DLY, LN_R_SLOW, LN_R_SDLY,
		LN_R_SHIGH, LN_R_BLOW, LN_R_BHIGH
	} line_phase_e;

	typedef enum int {WT_PENDING, WT_MET, WT_EXPIRED} wait_e;

	typedef struct {
		logic [1:0] op;
		logic [7:0] tx_byte;
		logic       clk_level;
		logic       data_level;
	} tick_word_t;

	// DUT signals
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_addr = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_WIDTH-1:0] s_tdata = '0;
	logic [IN_USER_WIDTH-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_WIDTH-1:0] m_tdata;

	// Model of the host sequencer
	logic [DELAY_WIDTH-1:0]   inh_ticks, req_ticks, rel_ticks, sta_ticks;
	logic [TIMEOUT_WIDTH-1:0] tmo_ticks;
	line_phase_e ln_phase;
	int unsigned wait_cnt;
	logic [7:0] shift_q;
	logic [3:0] bit_idx;
	logic       par_acc;
	logic [7:0] rx_last;
	logic       clk_held;

	// Stimulus and scoreboard
	tick_word_t tick_q[$];
	res_t expected_drive_q[$];
	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned n_errors = 0;
	int unsigned idle_cycles = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;

	// Pacing
	bit quiet = 1'b0;
	bit hold_quiet = 1'b0;
	int unsigned stretch_left = 0;
	int unsigned in_gap = 0;
	int unsigned out_stall = 0;

	// Device-side clock waveform
	logic wave_level = 1'b1;
	int unsigned wave_left = 0;
	int unsigned wave_max = 4;

	always #2 clk = ~clk;

	ps2_host_line_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// ------------------------------------------------------------------
	// Sequencer model
	// ------------------------------------------------------------------
	function automatic bit delay_elapsed(input int unsigned n);
		if (wait_cnt != 32'hFFFF_FFFF) wait_cnt++;
		if (n == 0 || wait_cnt >= n) begin
			wait_cnt = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Wait bounded by the timeout register; zero means no bound
	function automatic wait_e line_wait(input bit cond);
		if (cond) begin
			wait_cnt = 0;
			return WT_MET;
		end
		if (wait_cnt != 32'hFFFF_FFFF) wait_cnt++;
		if (tmo_ticks != 0 && wait_cnt >= tmo_ticks) begin
			wait_cnt = 0;
			return WT_EXPIRED;
		end
		return WT_PENDING;
	endfunction

	function automatic res_t predict_tick(input tick_word_t w);
		res_t r;
		wait_e ws;
		r = '0;
		ws = WT_PENDING;
		if (ln_phase == LN_IDLE && (w.op == OP_SEND || w.op == OP_RECV)) begin
			// start word only sets up; its line levels are ignored
			wait_cnt = 0;
			bit_idx = '0;
			par_acc = 1'b1;
			clk_held = 1'b0;
			shift_q = (w.op == OP_SEND) ? w.tx_byte : 8'h00;
			ln_phase = (w.op == OP_SEND) ? LN_S_REL : LN_R_DLY;
		end else begin
			case (ln_phase)
			LN_S_REL: if (delay_elapsed(inh_ticks)) ln_phase = LN_S_INH;
			LN_S_INH: if (delay_elapsed(inh_ticks)) ln_phase = LN_S_REQ;
			LN_S_REQ: if (delay_elapsed(req_ticks)) ln_phase = LN_S_WSTART;
			LN_S_WSTART: begin
				ws = line_wait(!w.clk_level);
				if (ws == WT_MET) ln_phase = LN_S_BHIGH;
			end
			LN_S_BHIGH: begin
				ws = line_wait(w.clk_level);
				if (ws == WT_MET) ln_phase = LN_S_BLOW;
			end
			LN_S_BLOW: begin
				ws = line_wait(!w.clk_level);
				if (ws == WT_MET) begin
					if (bit_idx < 8) begin
						par_acc ^= shift_q[0];
						shift_q >>= 1;
						bit_idx++;
						ln_phase = LN_S_BHIGH;
					end else begin
						ln_phase = LN_S_ACKDLY;
					end
				end
			end
			LN_S_ACKDLY: if (delay_elapsed(rel_ticks)) ln_phase = LN_S_ACKLOW;
			LN_S_ACKLOW: begin
				ws = line_wait(!w.clk_level);
				if (ws == WT_MET) ln_phase = LN_S_EITHER;
			end
			LN_S_EITHER: begin
				ws = line_wait(w.clk_level || w.data_level);
				if (ws == WT_MET) begin
					ln_phase = LN_IDLE;
					clk_held = 1'b1;
					r.tx_done = 1'b1;
				end
			end
			LN_R_DLY: if (delay_elapsed(rel_ticks)) ln_phase = LN_R_SLOW;
			LN_R_SLOW: if (!w.clk_level) ln_phase = LN_R_SDLY;
			LN_R_SDLY: if (delay_elapsed(sta_ticks)) ln_phase = LN_R_SHIGH;
			LN_R_SHIGH: if (w.clk_level) ln_phase = LN_R_BLOW;
			LN_R_BLOW: begin
				if (!w.clk_level) begin
					if (bit_idx < 8) shift_q = {w.data_level, shift_q[7:1]};
					bit_idx++;
					ln_phase = LN_R_BHIGH;
				end
			end
			LN_R_BHIGH: begin
				if (w.clk_level) begin
					if (bit_idx >= 10) begin
						rx_last = shift_q;
						r.rx_done = 1'b1;
						clk_held = 1'b1;
						ln_phase = LN_IDLE;
					end else begin
						ln_phase = LN_R_BLOW;
					end
				end
			end
			default: ;
			endcase
			// timeout drops data and parks the clock low
			if (ws == WT_EXPIRED) begin
				ln_phase = LN_IDLE;
				clk_held = 1'b1;
				r.tx_timeout = 1'b1;
			end
		end

		// line drives after this word
		case (ln_phase)
		LN_IDLE: r.clk_pull_low = clk_held;
		LN_S_INH: r.clk_pull_low = 1'b1;
		LN_S_REQ: begin
			r.clk_pull_low = 1'b1;
			r.data_pull_low = 1'b1;
		end
		LN_S_WSTART: r.data_pull_low = 1'b1;
		LN_S_BHIGH, LN_S_BLOW: r.data_pull_low = (bit_idx < 8) ? ~shift_q[0] : ~par_acc;
		default: ;
		endcase
		r.rx_byte = rx_last;
		r.busy_res = (ln_phase != LN_IDLE);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			n_errors++;
		end
	endfunction

	function automatic int unsigned draw_gap();
		if (quiet || hold_quiet) return 0;
		return $urandom_range(0, 8);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_word(input logic [1:0] op, input logic [7:0] txb,
			input logic clk_l, input logic dat_l);
		tick_word_t w;
		w.op = op;
		w.tx_byte = txb;
		w.clk_level = clk_l;
		w.data_level = dat_l;
		tick_q.push_back(w);
		words_queued++;
	endtask

	// Device clock as a square wave with random half periods; noisy mode
	// drops in stray commands now and then
	task automatic push_wave(input int unsigned n, input bit noisy);
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			if (wave_left == 0) begin
				wave_level = !wave_level;
				wave_left = $urandom_range(1, wave_max);
			end
			wave_left--;
			op = OP_TICK;
			if (noisy && $urandom_range(0, 15) == 0) op = 2'($urandom_range(0, 3));
			push_word(op, 8'($urandom_range(0, 255)), wave_level, 1'($urandom_range(0, 1)));
		end
	endtask

	// Lines frozen, as from a device that stopped responding
	task automatic push_stuck(input int unsigned n);
		logic clk_l, dat_l;
		clk_l = 1'($urandom_range(0, 1));
		dat_l = 1'($urandom_range(0, 1));
		for (int i = 0; i < n; i++)
			push_word(OP_TICK, 8'($urandom_range(0, 255)), clk_l, dat_l);
	endtask

	// One command followed by device activity, sometimes after a broken line
	task automatic push_session();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			push_word(OP_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else if (pick < 75)
			push_word(OP_RECV, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else if (pick < 85)
			push_word(pick[0] ? OP_TICK : OP_SPARE, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		else
			push_word(pick[0] ? OP_SEND : OP_RECV, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
		if (pick >= 85)
			push_stuck($urandom_range(1, 12));
		push_wave($urandom_range(8, 70), 1'b1);
	endtask

	// Wait until every queued word has been taken and its result checked
	task automatic drain_words();
		while (words_taken != words_queued || expected_drive_q.size() != 0)
			@(negedge clk);
	endtask

	// Wait for all words through, run the sequencer to idle, then let the
	// pipeline empty
	task automatic settle_idle();
		forever begin
			drain_words();
			if (ln_phase == LN_IDLE) break;
			push_wave(16, 1'b0);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge while the block is idle
	task automatic set_timing(input logic [DELAY_WIDTH-1:0] inh, input logic [DELAY_WIDTH-1:0] req,
			input logic [DELAY_WIDTH-1:0] rel, input logic [DELAY_WIDTH-1:0] sta,
			input logic [TIMEOUT_WIDTH-1:0] tmo);
		logic [CFG_IDX_WIDTH-1:0] idx [5];
		logic [CFG_DATA_WIDTH-1:0] vals [5];
		idx = '{REG_INHIBIT, REG_REQUEST, REG_RELEASE, REG_START, REG_TIMEOUT};
		vals = '{CFG_DATA_WIDTH'(inh), CFG_DATA_WIDTH'(req), CFG_DATA_WIDTH'(rel),
			CFG_DATA_WIDTH'(sta), CFG_DATA_WIDTH'(tmo)};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= idx[i];
			cfg_wdata <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		inh_ticks = inh;
		req_ticks = req;
		rel_ticks = rel;
		sta_ticks = sta;
		tmo_ticks = tmo;
	endtask

	// ------------------------------------------------------------------
	// Driver: input words and result backpressure, changed on falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		tick_word_t w;
		bit next_valid;
		if (arst_n) begin
			// alternate stretches with and without idling
			if (stretch_left == 0) begin
				quiet = !quiet;
				stretch_left = $urandom_range(20, 200);
			end
			stretch_left--;

			next_valid = s_tvalid && !in_taken;
			if (!next_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (tick_q.size() != 0) begin
					w = tick_q.pop_front();
					s_tdata <= {6'b0, w.data_level, w.clk_level, w.tx_byte};
					s_tuser <= w.op;
					next_valid = 1'b1;
					in_gap = draw_gap();
				end
			end
			s_tvalid <= next_valid;

			if (out_taken) out_stall = draw_gap();
			if (out_stall > 0) begin
				m_tready <= 1'b0;
				out_stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on input accept, compare on result accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tick_word_t w;
		res_t want, seen;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;

			if (m_tvalid && m_tready) begin
				if (expected_drive_q.size() == 0) begin
					$error("result word with no prediction pending: %0h", m_tdata);
					n_errors++;
				end else begin
					want = expected_drive_q.pop_front();
					seen = res_t'(m_tdata[RES_WIDTH-1:0]);
					check_field("clk_pull_low", want.clk_pull_low, seen.clk_pull_low);
					check_field("data_pull_low", want.data_pull_low, seen.data_pull_low);
					check_field("rx_byte", want.rx_byte, seen.rx_byte);
					check_field("rx_done", want.rx_done, seen.rx_done);
					check_field("tx_done", want.tx_done, seen.tx_done);
					check_field("tx_timeout", want.tx_timeout, seen.tx_timeout);
					check_field("busy_res", want.busy_res, seen.busy_res);
				end
			end

			if (s_tvalid && s_tready) begin
				w.op = s_tuser;
				w.tx_byte = s_tdata[7:0];
				w.clk_level = s_tdata[8];
				w.data_level = s_tdata[9];
				expected_drive_q.push_back(predict_tick(w));
				words_taken++;
			end
		end
	end

	// Watchdog on stalled traffic
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned mark;

		inh_ticks = INHIBIT_RST;
		req_ticks = REQUEST_RST;
		rel_ticks = RELEASE_RST;
		sta_ticks = START_RST;
		tmo_ticks = TIMEOUT_RST;
		ln_phase = LN_IDLE;
		wait_cnt = 0;
		shift_q = '0;
		bit_idx = '0;
		par_acc = 1'b1;
		rx_last = '0;
		clk_held = 1'b0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timing: one receive
		push_word(OP_RECV, 8'hC3, 1'b0, 1'b1);
		settle_idle();

		// zero delays (one tick each), no timeout
		set_timing('0, '0, '0, '0, '0);
		push_word(OP_TICK, 8'hFF, 1'b1, 1'b1);
		push_word(OP_SPARE, 8'h00, 1'b0, 1'b0);
		// start word with clock low: levels must be ignored
		push_word(OP_SEND, 8'hFF, 1'b0, 1'b0);
		repeat (3) push_word(OP_TICK, 8'h00, 1'b1, 1'b0);
		// clock never falls, no limit set: keep waiting
		push_word(OP_RECV, 8'h00, 1'b1, 1'b1);
		push_word(OP_SPARE, 8'hFF, 1'b1, 1'b0);
		push_word(OP_SEND, 8'h81, 1'b1, 1'b1);
		repeat (3) push_word(OP_TICK, 8'h7E, 1'b1, 1'b0);
		settle_idle();
		// tick while idle keeps the clock parked low
		push_word(OP_TICK, 8'hAA, 1'b1, 1'b1);
		push_word(OP_RECV, 8'h00, 1'b1, 1'b0);
		settle_idle();

		// shortest timeout: start wait expires
		set_timing('0, '0, '0, '0, 24'd1);
		push_word(OP_SEND, 8'h00, 1'b1, 1'b1);
		repeat (5) push_word(OP_TICK, 8'h55, 1'b1, 1'b1);
		push_word(OP_SEND, 8'h01, 1'b0, 1'b1);
		settle_idle();

		// random, tight timeouts
		wave_max = 4;
		set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 24'($urandom_range(1, 4)));
		mark = words_queued;
		while (words_queued - mark < 100) push_session();
		settle_idle();

		// random, no timeout
		set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
			16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), '0);
		mark = words_queued;
		while (words_queued - mark < 100) push_session();
		settle_idle();

		// largest settings at full rate: a receive held in its first delay
		hold_quiet = 1'b1;
		set_timing('1, '1, '1, '1, '1);
		push_word(OP_TICK, 8'h00, 1'b0, 1'b0);
		push_word(OP_RECV, 8'hFF, 1'b1, 1'b1);
		push_wave(40, 1'b0);
		drain_words();
		repeat (SETTLE_CYCLES) @(negedge clk);
		hold_quiet = 1'b0;

		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ps2h_pkg.sv
sv/ps2h_cfg_regs.sv
sv/ps2h_core.sv
sv/ps2_host_line_controller.sv
sv/ps2h_checker.sv
tb/tb.sv
